// ----- rtl/drl_pkg.sv -----
// ----------------------------------------------------------------------------
// drl_pkg: readout word deframer package
// shared constants, fatal codes and the types passed between the front,
// the queues and the back sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package drl_pkg;

  // event geometry
  localparam int ROWS             = 24;
  localparam int DILOGICS         = 10;
  localparam int PADS             = 48;
  localparam int ROWS_PER_SEGMENT = 8;
  localparam int MAX_ROW_WORDS    = 490;

  // signatures
  localparam logic [15:0] ROW_SIGNATURE = 16'h32a8;
  localparam logic [23:0] SEG_SIGNATURE = 24'hab0f59;

  // row-in-segment counter width (segment length up to 16 rows)
  localparam int RIS_W = 4;

  // fatal codes
  localparam logic [2:0] FATAL_NONE       = 3'd0;
  localparam logic [2:0] FATAL_MARK_SIZE  = 3'd1;
  localparam logic [2:0] FATAL_MARK_SIG   = 3'd2;
  localparam logic [2:0] FATAL_EOE_COUNT  = 3'd3;
  localparam logic [2:0] FATAL_EOE_DIL    = 3'd4;
  localparam logic [2:0] FATAL_EOE_ROW    = 3'd5;
  localparam logic [2:0] FATAL_SEG_SIG    = 3'd6;
  localparam logic [2:0] FATAL_SEG_INDEX  = 3'd7;

  // classified input word, front to back
  typedef struct packed {
    logic        start;
    logic        phys;
    logic [3:0]  link;
    logic        is_eoe;
    logic        size_bad;
    logic        mark_sig_ok;
    logic [8:0]  size9;
    logic [4:0]  row;
    logic [3:0]  dil;
    logic [5:0]  pad;
    logic [11:0] chg;
    logic [2:0]  errs;
    logic [6:0]  cnt7;
    logic        seg_sig_ok;
    logic [7:0]  seg_num;
  } drl_class_t;

  // one result item
  typedef struct packed {
    logic        hit_valid;
    logic [3:0]  link_out;
    logic [4:0]  row_out;
    logic [3:0]  dilogic_out;
    logic [5:0]  pad_out;
    logic [11:0] charge;
    logic [2:0]  index_errors;
    logic [2:0]  fatal_code;
    logic        event_done;
  } drl_result_t;

endpackage

`default_nettype wire

// ----- rtl/drl_fifo.sv -----
// ----------------------------------------------------------------------------
// drl_fifo: small first-word-fall-through queue
// register-based queue with count, head visible while not empty
// ----------------------------------------------------------------------------
`default_nettype none

module drl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] rdata,
  output      logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/drl_front.sv -----
// ----------------------------------------------------------------------------
// drl_front: word classifier
// splits each payload word into its marker, data, end-of-event and segment
// views and does all field compares that need no event state
// ----------------------------------------------------------------------------
`default_nettype none

module drl_front (
  input  wire logic              push,
  output      logic              full,
  input  wire logic [31:0]       word,
  input  wire logic              event_start,
  input  wire logic              physics,
  input  wire logic [3:0]        link_id,
  output      logic              q_push,
  output      drl_pkg::drl_class_t q_item,
  input  wire logic              q_full
);

  logic [11:0] size12;

  assign size12 = word[27:16];
  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_item             = '0;
    q_item.start       = event_start;
    q_item.phys        = physics;
    q_item.link        = link_id;
    q_item.is_eoe      = word[27];
    // marker view
    q_item.size_bad    = (size12 > 12'(drl_pkg::MAX_ROW_WORDS));
    q_item.mark_sig_ok = (word[15:0] == drl_pkg::ROW_SIGNATURE);
    q_item.size9       = size12[8:0];
    // data / end-of-event view
    q_item.row         = word[26:22];
    q_item.dil         = word[21:18];
    q_item.pad         = word[17:12];
    q_item.chg         = word[11:0];
    q_item.cnt7        = word[6:0];
    q_item.errs[0]     = (word[26:22] == '0) || (word[26:22] > 5'(drl_pkg::ROWS));
    q_item.errs[1]     = (word[21:18] == '0) || (word[21:18] > 4'(drl_pkg::DILOGICS));
    q_item.errs[2]     = ({1'b0, word[17:12]} >= 7'(drl_pkg::PADS));
    // segment view
    q_item.seg_sig_ok  = (word[31:8] == drl_pkg::SEG_SIGNATURE);
    q_item.seg_num     = word[7:0];
  end

endmodule

`default_nettype wire

// ----- rtl/drl_back.sv -----
// ----------------------------------------------------------------------------
// drl_back: event sequencer
// walks markers, data, end-of-event and segment words, one classified word
// per cycle while the result queue has room, and forms one result per word
// ----------------------------------------------------------------------------
`default_nettype none

module drl_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_empty,
  input  wire drl_pkg::drl_class_t in_item,
  output      logic                in_pop,
  input  wire logic                out_full,
  output      logic                out_push,
  output      drl_pkg::drl_result_t out_item
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_MARKER  = 2'd1;
  localparam logic [1:0] PH_DATA    = 2'd2;
  localparam logic [1:0] PH_SEGMENT = 2'd3;

  localparam int RW = drl_pkg::RIS_W;

  logic [1:0]    phase, phase_next;
  logic [4:0]    row_count, row_count_next;
  logic [8:0]    words_left, words_left_next;
  logic [8:0]    data_count, data_count_next;
  logic [4:0]    last_row, last_row_next;
  logic [3:0]    last_dilogic, last_dilogic_next;
  logic [3:0]    event_link, event_link_next;
  logic [RW-1:0] rows_in_seg, rows_in_seg_next;
  logic [4:0]    seg_index, seg_index_next;

  assign in_pop   = !in_empty && !out_full;
  assign out_push = in_pop;

  always_comb begin
    phase_next        = phase;
    row_count_next    = row_count;
    words_left_next   = words_left;
    data_count_next   = data_count;
    last_row_next     = last_row;
    last_dilogic_next = last_dilogic;
    event_link_next   = event_link;
    rows_in_seg_next  = rows_in_seg;
    seg_index_next    = seg_index;
    out_item          = '0;

    if (in_item.start) begin
      event_link_next   = in_item.link;
      row_count_next    = '0;
      words_left_next   = '0;
      data_count_next   = '0;
      last_row_next     = '0;
      last_dilogic_next = '0;
      rows_in_seg_next  = '0;
      seg_index_next    = '0;
      phase_next        = in_item.phys ? PH_MARKER : PH_IDLE;
    end

    unique case (phase_next)
      PH_MARKER: begin
        if (in_item.size_bad) begin
          out_item.fatal_code = drl_pkg::FATAL_MARK_SIZE;
          phase_next          = PH_IDLE;
        end else if (!in_item.mark_sig_ok) begin
          out_item.fatal_code = drl_pkg::FATAL_MARK_SIG;
          phase_next          = PH_IDLE;
        end else begin
          row_count_next    = row_count_next + 1'b1;
          words_left_next   = in_item.size9;
          data_count_next   = '0;
          last_row_next     = '0;
          last_dilogic_next = '0;
          if (rows_in_seg_next == RW'(drl_pkg::ROWS_PER_SEGMENT - 1)) begin
            rows_in_seg_next = '0;
            seg_index_next   = seg_index_next + 1'b1;
          end else begin
            rows_in_seg_next = rows_in_seg_next + 1'b1;
          end
          if (in_item.size9 == '0) begin
            // empty row ends on its marker
            if (rows_in_seg_next == '0) begin
              phase_next = PH_SEGMENT;
            end else if (row_count_next >= 5'(drl_pkg::ROWS)) begin
              phase_next          = PH_IDLE;
              out_item.event_done = 1'b1;
            end else begin
              phase_next = PH_MARKER;
            end
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (!in_item.is_eoe) begin
          out_item.row_out      = in_item.row;
          out_item.dilogic_out  = in_item.dil;
          out_item.pad_out      = in_item.pad;
          out_item.charge       = in_item.chg;
          out_item.index_errors = in_item.errs;
          out_item.hit_valid    = (in_item.errs == '0);
          data_count_next       = data_count_next + 1'b1;
          last_row_next         = in_item.row;
          last_dilogic_next     = in_item.dil;
        end else if ({2'b00, in_item.cnt7} != data_count_next) begin
          out_item.fatal_code = drl_pkg::FATAL_EOE_COUNT;
        end else if (data_count_next != '0 && in_item.dil != last_dilogic_next) begin
          out_item.fatal_code = drl_pkg::FATAL_EOE_DIL;
        end else if (data_count_next != '0 && in_item.row != last_row_next) begin
          out_item.fatal_code = drl_pkg::FATAL_EOE_ROW;
        end else begin
          data_count_next = '0;
        end

        if (out_item.fatal_code != drl_pkg::FATAL_NONE) begin
          phase_next = PH_IDLE;
        end else begin
          words_left_next = words_left_next - 1'b1;
          if (words_left_next == '0) begin
            if (rows_in_seg_next == '0) begin
              phase_next = PH_SEGMENT;
            end else if (row_count_next >= 5'(drl_pkg::ROWS)) begin
              phase_next          = PH_IDLE;
              out_item.event_done = 1'b1;
            end else begin
              phase_next = PH_MARKER;
            end
          end
        end
      end
      PH_SEGMENT: begin
        if (!in_item.seg_sig_ok) begin
          out_item.fatal_code = drl_pkg::FATAL_SEG_SIG;
          phase_next          = PH_IDLE;
        end else if (in_item.seg_num != {3'b000, seg_index_next}) begin
          out_item.fatal_code = drl_pkg::FATAL_SEG_INDEX;
          phase_next          = PH_IDLE;
        end else if (row_count_next >= 5'(drl_pkg::ROWS)) begin
          out_item.event_done = 1'b1;
          phase_next          = PH_IDLE;
        end else begin
          phase_next = PH_MARKER;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    out_item.link_out = event_link_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      row_count    <= '0;
      words_left   <= '0;
      data_count   <= '0;
      last_row     <= '0;
      last_dilogic <= '0;
      event_link   <= '0;
      rows_in_seg  <= '0;
      seg_index    <= '0;
    end else if (in_pop) begin
      phase        <= phase_next;
      row_count    <= row_count_next;
      words_left   <= words_left_next;
      data_count   <= data_count_next;
      last_row     <= last_row_next;
      last_dilogic <= last_dilogic_next;
      event_link   <= event_link_next;
      rows_in_seg  <= rows_in_seg_next;
      seg_index    <= seg_index_next;
    end
  end

  // a fatal error or a finished event always drops back to idle
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_push && (out_item.event_done || out_item.fatal_code != drl_pkg::FATAL_NONE))
    |=> (phase == PH_IDLE))
    else $error("sequencer not idle after fatal error or event end");

  // data phase always has words left in the row
  a_data_words: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (words_left != '0))
    else $error("data phase with no words left");

  // row count never passes the event length
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (row_count <= 5'(drl_pkg::ROWS)))
    else $error("row count beyond event length");

  // the segment position stays inside one segment
  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    (rows_in_seg <= RW'(drl_pkg::ROWS_PER_SEGMENT - 1)))
    else $error("row-in-segment counter out of range");

  // state only moves when a word is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !in_pop |=> $stable(phase) && $stable(row_count) && $stable(words_left))
    else $error("sequencer state changed without a word");

endmodule

`default_nettype wire

// ----- rtl/detector_readout_word_deframer_top.sv -----
// ----------------------------------------------------------------------------
// detector_readout_word_deframer_top: readout link word deframer
// classifies payload words, walks the row / segment framing of each physics
// event and reports one result per word
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one payload word per clock while full is low, and gives
// exactly one result per word, in order. A request enters with push while
// full is low; its result passes the classified-word queue, the sequencer
// and the result queue to the output ports with empty low, and leaves with
// pop. Sustained rate is one word per clock while results are popped, set
// by the back sequencer, which retires one classified word per cycle.
// A front classifier does every compare that needs no event state; a
// QUEUE_DEPTH-entry queue lies between it and the sequencer, and a
// two-entry result queue lies after, so a stalled consumer fills the
// queues before full is raised. Hits with indices out of range carry
// index_errors and a low hit_valid; a fatal_code stops parsing until the
// next event start, and event_done marks the word that completes an event.
module detector_readout_word_deframer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input side
  input  wire logic        push,
  output      logic        full,
  input  wire logic [31:0] word,
  input  wire logic        event_start,
  input  wire logic        physics,
  input  wire logic [3:0]  link_id,
  // result side
  output      logic        empty,
  input  wire logic        pop,
  output      logic        hit_valid,
  output      logic [3:0]  link_out,
  output      logic [4:0]  row_out,
  output      logic [3:0]  dilogic_out,
  output      logic [5:0]  pad_out,
  output      logic [11:0] charge,
  output      logic [2:0]  index_errors,
  output      logic [2:0]  fatal_code,
  output      logic        event_done
);

  localparam int CLASS_W  = $bits(drl_pkg::drl_class_t);
  localparam int RESULT_W = $bits(drl_pkg::drl_result_t);
  // two entries keep one result per clock flowing under a steady pop
  localparam int RES_DEPTH = 2;

  // front to classified-word queue
  logic                 cq_push;
  logic                 cq_full;
  drl_pkg::drl_class_t  cq_wdata;
  // classified-word queue to sequencer
  logic                 cq_empty;
  logic                 cq_pop;
  drl_pkg::drl_class_t  cq_rdata;
  // sequencer to result queue
  logic                 rq_full;
  logic                 rq_push;
  drl_pkg::drl_result_t rq_wdata;
  drl_pkg::drl_result_t rq_rdata;

  // classify each word as it arrives
  drl_front u_front (
    .push        (push),
    .full        (full),
    .word        (word),
    .event_start (event_start),
    .physics     (physics),
    .link_id     (link_id),
    .q_push      (cq_push),
    .q_item      (cq_wdata),
    .q_full      (cq_full)
  );

  // decoupling queue between classifier and sequencer
  drl_fifo #(
    .WIDTH (CLASS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_class_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  // framing sequencer
  drl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_empty (cq_empty),
    .in_item  (cq_rdata),
    .in_pop   (cq_pop),
    .out_full (rq_full),
    .out_push (rq_push),
    .out_item (rq_wdata)
  );

  // result queue, head drives the result ports
  drl_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (RES_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign hit_valid    = rq_rdata.hit_valid;
  assign link_out     = rq_rdata.link_out;
  assign row_out      = rq_rdata.row_out;
  assign dilogic_out  = rq_rdata.dilogic_out;
  assign pad_out      = rq_rdata.pad_out;
  assign charge       = rq_rdata.charge;
  assign index_errors = rq_rdata.index_errors;
  assign fatal_code   = rq_rdata.fatal_code;
  assign event_done   = rq_rdata.event_done;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: readout word deframer testbench
// drives payload words through the push / full side and pops results from
// the empty / pop side, with random idle bursts and one long consumer
// hold-off; every result is checked field by field against an in-bench
// model of the row / segment framing, or against a value typed into the
// directed table where it is obvious
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 7;
  localparam int LIVE_TARGET  = 850;     // parsed words wanted in the random part
  localparam int QUIET_TAIL   = 100;     // final requests sent with no idling
  localparam int HOLD_AT      = 400;     // result count that starts the long hold-off
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  // parser phase of the in-bench model
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARKER,
    ST_ROW_WORDS,
    ST_SEGMENT
  } deframe_phase_t;

  // one request, with an optional hand-typed result
  typedef struct packed {
    logic [31:0]          word;
    logic                 start;
    logic                 phys;
    logic [3:0]           link;
    logic                 typed;
    drl_pkg::drl_result_t want;
  } word_req_t;

  // directed table: reset, non-physics start, marker errors, index extremes,
  // empty row, end-of-event errors and an event restarted mid-way
  localparam int DIR_ROWS = 26;
  localparam word_req_t DIRECTED [DIR_ROWS] = '{
    // idle after reset: everything zero
    '{32'hFFFFFFFF, 1'b0, 1'b1, 4'd15, 1'b1,
      '{1'b0, 4'd0, 5'd0, 4'd0, 6'd0, 12'd0, 3'd0, drl_pkg::FATAL_NONE, 1'b0}},
    // non-physics start only takes the link
    '{32'h000532A8, 1'b1, 1'b0, 4'd15, 1'b1,
      '{1'b0, 4'd15, 5'd0, 4'd0, 6'd0, 12'd0, 3'd0, drl_pkg::FATAL_NONE, 1'b0}},
    '{32'h000532A8, 1'b0, 1'b1, 4'd0, 1'b1,
      '{1'b0, 4'd15, 5'd0, 4'd0, 6'd0, 12'd0, 3'd0, drl_pkg::FATAL_NONE, 1'b0}},
    // marker size just over the limit, then the largest size field
    '{32'h01EB32A8, 1'b1, 1'b1, 4'd3, 1'b1,
      '{1'b0, 4'd3, 5'd0, 4'd0, 6'd0, 12'd0, 3'd0, drl_pkg::FATAL_MARK_SIZE, 1'b0}},
    '{32'hFFFF32A8, 1'b1, 1'b1, 4'd4, 1'b1,
      '{1'b0, 4'd4, 5'd0, 4'd0, 6'd0, 12'd0, 3'd0, drl_pkg::FATAL_MARK_SIZE, 1'b0}},
    // signature one off
    '{32'h000032A9, 1'b1, 1'b1, 4'd0, 1'b1,
      '{1'b0, 4'd0, 5'd0, 4'd0, 6'd0, 12'd0, 3'd0, drl_pkg::FATAL_MARK_SIG, 1'b0}},
    // five-word row: low-edge hit, all-ones indices, zero indices, just over
    '{32'h000532A8, 1'b1, 1'b1, 4'd5, 1'b0, '0},
    '{32'hF0440FFF, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    '{32'h07FFF000, 1'b0, 1'b1, 4'd9, 1'b1,
      '{1'b0, 4'd5, 5'd31, 4'd15, 6'd63, 12'd0, 3'd7, drl_pkg::FATAL_NONE, 1'b0}},
    '{32'h00030555, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    '{32'h066EF123, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    '{32'hAE6FFF84, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    // empty row
    '{32'h000032A8, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    // upper-edge hit, then end-of-event with the wrong dilogic
    '{32'h000332A8, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    '{32'h062AF800, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    '{32'h0E240001, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    // restart mid-event, then end-of-event with the wrong row
    '{32'h000232A8, 1'b1, 1'b1, 4'd9, 1'b0, '0},
    '{32'h008C50AA, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    '{32'h000232A8, 1'b1, 1'b1, 4'd10, 1'b0, '0},
    '{32'h008C50AA, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    '{32'h09CC0001, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    // end-of-event word count wrong
    '{32'h000132A8, 1'b1, 1'b1, 4'd12, 1'b0, '0},
    '{32'h08000005, 1'b0, 1'b0, 4'd0, 1'b1,
      '{1'b0, 4'd12, 5'd0, 4'd0, 6'd0, 12'd0, 3'd0, drl_pkg::FATAL_EOE_COUNT, 1'b0}},
    // end-of-event with no data: row and dilogic not compared
    '{32'h000232A8, 1'b1, 1'b1, 4'd1, 1'b0, '0},
    '{32'h0FFFFF80, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    // non-physics start cuts the open event short
    '{32'h00000000, 1'b1, 1'b0, 4'd6, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] word = '0;
  logic        event_start = 1'b0;
  logic        physics = 1'b0;
  logic [3:0]  link_id = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        hit_valid;
  logic [3:0]  link_out;
  logic [4:0]  row_out;
  logic [3:0]  dilogic_out;
  logic [5:0]  pad_out;
  logic [11:0] charge;
  logic [2:0]  index_errors;
  logic [2:0]  fatal_code;
  logic        event_done;

  // request list, and the results still owed by the block
  word_req_t            word_reqs [$];
  drl_pkg::drl_result_t pending_results [$];

  // model state, starting from the reset values
  deframe_phase_t dphase     = ST_IDLE;
  logic [4:0]     rows_seen  = '0;
  logic [8:0]     words_left = '0;
  logic [8:0]     data_words = '0;
  logic [4:0]     last_row   = '0;
  logic [3:0]     last_dil   = '0;
  logic [3:0]     ev_link    = '0;

  int live_items   = 0;
  int results_seen = 0;
  int error_count  = 0;
  int hits_seen    = 0;
  int events_seen  = 0;
  int fatals_seen  = 0;
  int cycle_count  = 0;

  detector_readout_word_deframer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .word         (word),
    .event_start  (event_start),
    .physics      (physics),
    .link_id      (link_id),
    .empty        (empty),
    .pop          (pop),
    .hit_valid    (hit_valid),
    .link_out     (link_out),
    .row_out      (row_out),
    .dilogic_out  (dilogic_out),
    .pad_out      (pad_out),
    .charge       (charge),
    .index_errors (index_errors),
    .fatal_code   (fatal_code),
    .event_done   (event_done)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // what follows a finished row; high when the event is complete
  function automatic logic close_row();
    if (rows_seen % drl_pkg::ROWS_PER_SEGMENT == 0) begin
      dphase = ST_SEGMENT;
      return 1'b0;
    end
    if (rows_seen >= drl_pkg::ROWS) begin
      dphase = ST_IDLE;
      return 1'b1;
    end
    dphase = ST_MARKER;
    return 1'b0;
  endfunction

  // one payload word through the framing walk
  task automatic deframe_word(input logic [31:0] w, input logic s, input logic p,
                              input logic [3:0] l, output drl_pkg::drl_result_t r);
    logic [11:0] mark_size;
    logic        counted;
    r         = '0;
    counted   = 1'b1;
    mark_size = w[27:16];
    if (s) begin
      ev_link    = l;
      rows_seen  = '0;
      words_left = '0;
      data_words = '0;
      last_row   = '0;
      last_dil   = '0;
      dphase     = p ? ST_MARKER : ST_IDLE;
    end
    case (dphase)
      ST_MARKER: begin
        if (mark_size > drl_pkg::MAX_ROW_WORDS) begin
          r.fatal_code = drl_pkg::FATAL_MARK_SIZE;
          dphase = ST_IDLE;
        end else if (w[15:0] != drl_pkg::ROW_SIGNATURE) begin
          r.fatal_code = drl_pkg::FATAL_MARK_SIG;
          dphase = ST_IDLE;
        end else begin
          rows_seen  = rows_seen + 5'd1;
          words_left = mark_size[8:0];
          data_words = '0;
          last_row   = '0;
          last_dil   = '0;
          if (words_left == 0) r.event_done = close_row();
          else dphase = ST_ROW_WORDS;
        end
      end
      ST_ROW_WORDS: begin
        if (!w[27]) begin
          // data word: fields always reported, hit only when all in range
          r.row_out     = w[26:22];
          r.dilogic_out = w[21:18];
          r.pad_out     = w[17:12];
          r.charge      = w[11:0];
          if (w[26:22] < 1 || w[26:22] > drl_pkg::ROWS) r.index_errors[0] = 1'b1;
          if (w[21:18] < 1 || w[21:18] > drl_pkg::DILOGICS) r.index_errors[1] = 1'b1;
          if (w[17:12] >= drl_pkg::PADS) r.index_errors[2] = 1'b1;
          r.hit_valid = (r.index_errors == 3'd0);
          data_words  = data_words + 9'd1;
          last_row    = w[26:22];
          last_dil    = w[21:18];
        end else begin
          // end-of-event: 7-bit count, then address of the last data word
          if ({2'b00, w[6:0]} != data_words) begin
            r.fatal_code = drl_pkg::FATAL_EOE_COUNT;
          end else if (data_words != 0 && w[21:18] != last_dil) begin
            r.fatal_code = drl_pkg::FATAL_EOE_DIL;
          end else if (data_words != 0 && w[26:22] != last_row) begin
            r.fatal_code = drl_pkg::FATAL_EOE_ROW;
          end else begin
            data_words = '0;
          end
          if (r.fatal_code != drl_pkg::FATAL_NONE) begin
            counted = 1'b0;
            dphase  = ST_IDLE;
          end
        end
        if (counted) begin
          words_left = words_left - 9'd1;
          if (words_left == 0) r.event_done = close_row();
        end
      end
      ST_SEGMENT: begin
        if (w[31:8] != drl_pkg::SEG_SIGNATURE) begin
          r.fatal_code = drl_pkg::FATAL_SEG_SIG;
          dphase = ST_IDLE;
        end else if (w[7:0] != rows_seen / drl_pkg::ROWS_PER_SEGMENT) begin
          r.fatal_code = drl_pkg::FATAL_SEG_INDEX;
          dphase = ST_IDLE;
        end else if (rows_seen >= drl_pkg::ROWS) begin
          r.event_done = 1'b1;
          dphase = ST_IDLE;
        end else begin
          dphase = ST_MARKER;
        end
      end
      default: ;
    endcase
    r.link_out = ev_link;
  endtask

  // ------------------------------------------------------------- stimulus

  // queue one random-part request; a rare bit flip breaks the framing
  task automatic push_word(input logic [31:0] w, input logic s, input logic p,
                           input logic [3:0] l, input logic parsed);
    word_req_t req;
    req = '0;
    if ($urandom_range(0, 79) == 0) w = w ^ (32'h1 << $urandom_range(0, 31));
    // link and physics only matter at a start
    if (!s) begin
      p = 1'($urandom);
      l = 4'($urandom);
    end
    req.word  = w;
    req.start = s;
    req.phys  = p;
    req.link  = l;
    word_reqs.push_back(req);
    if (parsed) live_items++;
  endtask

  // one event: mostly well-formed rows with random content
  task automatic build_event();
    logic [3:0]  link;
    logic        phys;
    logic [4:0]  lastr;
    logic [3:0]  lastd;
    logic [31:0] w;
    logic [31:0] row_words [$];
    int          k;
    link = 4'($urandom);
    phys = ($urandom_range(0, 7) != 0);
    if (!phys) begin
      push_word($urandom, 1'b1, 1'b0, link, 1'b0);
      repeat ($urandom_range(0, 4)) push_word($urandom, 1'b0, 1'b0, link, 1'b0);
      return;
    end
    for (int row = 1; row <= drl_pkg::ROWS; row++) begin
      // abandoned event: the next start cuts it off
      if ($urandom_range(0, 149) == 0) return;
      row_words.delete();
      repeat ($urandom_range(1, 2)) begin
        // rare long group, past the 7-bit count now and then
        k = ($urandom_range(0, 149) == 0) ? $urandom_range(120, 200)
                                          : $urandom_range(0, 3);
        lastr = 5'($urandom);
        lastd = 4'($urandom);
        repeat (k) begin
          w     = $urandom;
          w[27] = 1'b0;
          if ($urandom_range(0, 7) != 0) begin
            w[26:22] = 5'($urandom_range(1, drl_pkg::ROWS));
            w[21:18] = 4'($urandom_range(1, drl_pkg::DILOGICS));
            w[17:12] = 6'($urandom_range(0, drl_pkg::PADS - 1));
          end
          lastr = w[26:22];
          lastd = w[21:18];
          row_words.push_back(w);
        end
        w        = $urandom;
        w[27]    = 1'b1;
        w[26:22] = lastr;
        w[21:18] = lastd;
        w[6:0]   = k[6:0];
        row_words.push_back(w);
      end
      w        = $urandom;
      w[27:16] = 12'(row_words.size());
      w[15:0]  = drl_pkg::ROW_SIGNATURE;
      push_word(w, row == 1, 1'b1, link, 1'b1);
      foreach (row_words[i]) push_word(row_words[i], 1'b0, 1'b1, link, 1'b1);
      if (row % drl_pkg::ROWS_PER_SEGMENT == 0) begin
        w = {drl_pkg::SEG_SIGNATURE, 8'(row / drl_pkg::ROWS_PER_SEGMENT)};
        // broken segment word, in signature or number
        if ($urandom_range(0, 7) == 0) w = w ^ (32'h1 << $urandom_range(0, 31));
        push_word(w, 1'b0, 1'b1, link, 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------- sides

  // sender: offers requests at the falling edge, counts them at the rising
  task automatic send_words();
    drl_pkg::drl_result_t r;
    int                   idx;
    int                   gap;
    idx = 0;
    gap = 0;
    while (idx < word_reqs.size()) begin
      @(negedge clk);
      if (gap > 0) begin
        push <= 1'b0;
        gap--;
      end else if (idx < word_reqs.size() - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        // idle burst
        push <= 1'b0;
        gap = $urandom_range(0, 2);
      end else begin
        push        <= 1'b1;
        word        <= word_reqs[idx].word;
        event_start <= word_reqs[idx].start;
        physics     <= word_reqs[idx].phys;
        link_id     <= word_reqs[idx].link;
      end
      @(posedge clk);
      if (push && full === 1'b0) begin
        deframe_word(word_reqs[idx].word, word_reqs[idx].start, word_reqs[idx].phys,
                     word_reqs[idx].link, r);
        pending_results.push_back(word_reqs[idx].typed ? word_reqs[idx].want : r);
        idx++;
      end
    end
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t result %0d %s: expected %0h, actual %0h",
               $time, results_seen, name, want_v, got_v);
      error_count++;
    end
  endtask

  // receiver: random stalls, one long hold-off, then compares each result
  task automatic take_results();
    drl_pkg::drl_result_t got;
    drl_pkg::drl_result_t want;
    int                   stall;
    int                   hold;
    stall = 0;
    hold  = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (results_seen < word_reqs.size() - QUIET_TAIL &&
                   $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && empty === 1'b0) begin
        got = {hit_valid, link_out, row_out, dilogic_out, pad_out, charge,
               index_errors, fatal_code, event_done};
        results_seen++;
        if (got.hit_valid) hits_seen++;
        if (got.event_done) events_seen++;
        if (got.fatal_code != drl_pkg::FATAL_NONE) fatals_seen++;
        // long hold-off so the queues fill and full goes up
        if (results_seen == HOLD_AT) hold = HOLD_CYCLES;
        if (pending_results.size() == 0) begin
          $display("%0t result %0d: expected none, actual %0h", $time, results_seen, got);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("hit_valid", want.hit_valid, got.hit_valid);
          check_field("link_out", want.link_out, got.link_out);
          check_field("row_out", want.row_out, got.row_out);
          check_field("dilogic_out", want.dilogic_out, got.dilogic_out);
          check_field("pad_out", want.pad_out, got.pad_out);
          check_field("charge", want.charge, got.charge);
          check_field("index_errors", want.index_errors, got.index_errors);
          check_field("fatal_code", want.fatal_code, got.fatal_code);
          check_field("event_done", want.event_done, got.event_done);
        end
      end
    end
  endtask

  // ----------------------------------------------------------------- main

  initial begin
    // directed table first, then random events with noise between them
    for (int i = 0; i < DIR_ROWS; i++) word_reqs.push_back(DIRECTED[i]);
    while (live_items < LIVE_TARGET) begin
      repeat ($urandom_range(0, 2)) push_word($urandom, 1'b0, 1'b0, 4'd0, 1'b0);
      build_event();
    end

    // synchronous reset, released at a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fork
      send_words();
      take_results();
    join_any

    // every request is in; wait for the owed results, then a short drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d payload words sent, %0d results checked, %0d mismatches",
             word_reqs.size(), results_seen, error_count);
    $display("valid hits %0d, completed events %0d, fatal framing errors %0d",
             hits_seen, events_seen, fatals_seen);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
